// File: hw/rtl/ttsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsp_pkg
// Shared types and constants of the transposition table store and probe block.
// ----------------------------------------------------------------------------
package ttsp_pkg;

  localparam int TABLE_ENTRIES = 65536;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int MAX_DEPTH     = 64;
  localparam int DEPTH_W       = 6;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 16;

  localparam logic signed [15:0] SCORE_LIM      = 16'sd32767;
  localparam logic [14:0]        MATE_THR_RESET = 15'd29000;

  typedef enum logic [1:0] {
    OP_STORE      = 2'd0,
    OP_PROBE      = 2'd1,
    OP_PROBE_MOVE = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  localparam logic [1:0] BOUND_UPPER = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_EXACT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_AGE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MATE_THRESHOLD = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]          op;
    logic [63:0]         pos_key;
    logic [24:0]         move_in;
    logic signed [15:0]  score_in;
    logic [1:0]          bound_kind;
    logic [DEPTH_W-1:0]  search_depth;
    logic [5:0]          ply;
    logic signed [15:0]  alpha;
    logic signed [15:0]  beta;
  } ttsp_req_t;

  typedef struct packed {
    logic                key_matched;
    logic                cutoff;
    logic [24:0]         move_out;
    logic signed [15:0]  score_out;
    logic                was_stored;
    logic [31:0]         probe_hits;
    logic [31:0]         new_writes;
  } ttsp_rsp_t;

  typedef struct packed {
    logic [63:0]         key;
    logic [24:0]         move;
    logic signed [15:0]  score;
    logic [DEPTH_W-1:0]  depth;
    logic [1:0]          bound;
    logic [7:0]          age;
  } ttsp_slot_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic sweep;
  } ttsp_cmd_t;

  typedef struct packed {
    logic req_clear;
    logic sweep_last;
    logic out_stall;
  } ttsp_sts_t;

endpackage

// File: hw/rtl/ttsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsp_if
// Handshake channels of the transposition table: request, response, config.
// ----------------------------------------------------------------------------
interface ttsp_req_if import ttsp_pkg::*; ();
  logic      valid;
  logic      ready;
  ttsp_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ttsp_rsp_if import ttsp_pkg::*; ();
  logic      valid;
  logic      ready;
  ttsp_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ttsp_cfg_if import ttsp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/ttsp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsp_ctrl
// Sequencer: table sweep after reset and on clear, item accept, evaluation.
// ----------------------------------------------------------------------------
module ttsp_ctrl import ttsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ttsp_sts_t sts,
  output ttsp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EVAL,
    ST_CLEAR
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.req_clear ? ST_CLEAR : ST_EVAL;
        end
      end
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!sts.out_stall) begin
          cmd.eval   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/ttsp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsp_dp
// Slot memory, replacement and probe decision, counters and result register.
// ----------------------------------------------------------------------------
module ttsp_dp import ttsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ttsp_cmd_t             cmd,
  output ttsp_sts_t             sts,
  input  ttsp_req_t             req_data,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output ttsp_rsp_t             rsp_data
);

  localparam logic [DEPTH_W:0] DEPTH_CAP = (DEPTH_W+1)'(MAX_DEPTH - 1);

  function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = SCORE_LIM;
    end else if (v < -17'sd32767) begin
      r = -SCORE_LIM;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [15:0] v);
    return (v == -16'sd32768) ? -SCORE_LIM : v;
  endfunction

  ttsp_slot_t mem [TABLE_ENTRIES];
  ttsp_slot_t rd;
  ttsp_req_t  it;
  logic [IDX_W-1:0] sweep_cnt;

  logic [7:0]  current_age;
  logic [14:0] mate_threshold;
  logic [31:0] hit_counter;
  logic [31:0] empty_write_counter;

  ttsp_rsp_t  rsp_q;
  logic       out_valid;

  logic [IDX_W-1:0]   it_idx;
  logic signed [16:0] thr;
  logic signed [16:0] ply17;
  logic signed [16:0] st_s17;
  logic signed [16:0] pr_s17;
  logic signed [15:0] score_q;
  logic signed [15:0] alpha_q;
  logic signed [15:0] beta_q;
  logic signed [15:0] st_score;
  logic signed [15:0] pr_score;
  logic [DEPTH_W-1:0] st_depth;
  logic               is_store;
  logic               is_probe;
  logic               is_clear;
  logic               slot_empty;
  logic               replace;
  logic               match;
  logic               hit;
  logic               cut;
  logic signed [15:0] cut_score;
  logic [31:0]        hits_next;
  logic [31:0]        writes_next;
  ttsp_slot_t         new_slot;
  ttsp_rsp_t          rsp_next;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  ttsp_slot_t         mem_wd;

  assign it_idx   = it.pos_key[IDX_W-1:0];
  assign is_store = (it.op == OP_STORE);
  assign is_probe = (it.op == OP_PROBE) || (it.op == OP_PROBE_MOVE);
  assign is_clear = (it.op == OP_CLEAR);

  assign thr     = {2'b00, mate_threshold};
  assign ply17   = {11'b0, it.ply};
  assign score_q = sat16(it.score_in);
  assign alpha_q = sat16(it.alpha);
  assign beta_q  = sat16(it.beta);
  assign st_s17  = {score_q[15], score_q};
  assign pr_s17  = {rd.score[15], rd.score};

  // mate scores relative to ply on store, back to root on probe
  always_comb begin
    if (st_s17 > thr) begin
      st_score = sat17(st_s17 + ply17);
    end else if (st_s17 < -thr) begin
      st_score = sat17(st_s17 - ply17);
    end else begin
      st_score = score_q;
    end
    if (pr_s17 > thr) begin
      pr_score = sat17(pr_s17 - ply17);
    end else if (pr_s17 < -thr) begin
      pr_score = sat17(pr_s17 + ply17);
    end else begin
      pr_score = rd.score;
    end
  end

  assign st_depth = ({1'b0, it.search_depth} > DEPTH_CAP) ? DEPTH_CAP[DEPTH_W-1:0]
                                                         : it.search_depth;

  assign slot_empty = (rd.key == 64'd0);
  assign replace    = slot_empty || (rd.age < current_age) || (rd.depth <= it.search_depth);
  assign match      = (rd.key == it.pos_key);
  assign hit        = (it.op == OP_PROBE) && match && (rd.depth >= it.search_depth);

  always_comb begin
    cut       = 1'b0;
    cut_score = '0;
    if (hit) begin
      case (rd.bound)
        BOUND_UPPER: begin
          if (pr_score <= alpha_q) begin
            cut       = 1'b1;
            cut_score = alpha_q;
          end
        end
        BOUND_LOWER: begin
          if (pr_score >= beta_q) begin
            cut       = 1'b1;
            cut_score = beta_q;
          end
        end
        BOUND_EXACT: begin
          cut       = 1'b1;
          cut_score = pr_score;
        end
        default: begin
          cut = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    hits_next   = hit ? hit_counter + 32'd1 : hit_counter;
    writes_next = empty_write_counter;
    if (is_clear) begin
      writes_next = '0;
    end else if (is_store && slot_empty) begin
      writes_next = empty_write_counter + 32'd1;
    end
  end

  always_comb begin
    new_slot.key   = it.pos_key;
    new_slot.move  = it.move_in;
    new_slot.score = st_score;
    new_slot.depth = st_depth;
    new_slot.bound = it.bound_kind;
    new_slot.age   = current_age;
  end

  always_comb begin
    rsp_next.key_matched = is_probe && match;
    rsp_next.cutoff      = cut;
    rsp_next.move_out    = (is_probe && match) ? rd.move : 25'd0;
    rsp_next.score_out   = cut_score;
    rsp_next.was_stored  = is_store && replace;
    rsp_next.probe_hits  = hits_next;
    rsp_next.new_writes  = writes_next;
  end

  assign mem_we = cmd.sweep || (cmd.eval && is_store && replace);
  assign mem_wa = cmd.sweep ? sweep_cnt : it_idx;
  assign mem_wd = cmd.sweep ? '0 : new_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.load) begin
      rd <= mem[req_data.pos_key[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it <= req_data;
    end
    if (cmd.eval) begin
      rsp_q <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt           <= '0;
      current_age         <= '0;
      mate_threshold      <= MATE_THR_RESET;
      hit_counter         <= '0;
      empty_write_counter <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + IDX_W'(1);
      end
      if (cfg_valid && cfg_index == CFG_CURRENT_AGE) begin
        current_age <= cfg_data[7:0];
      end
      if (cfg_valid && cfg_index == CFG_MATE_THRESHOLD) begin
        mate_threshold <= cfg_data[14:0];
      end
      if (cmd.eval) begin
        hit_counter         <= hits_next;
        empty_write_counter <= writes_next;
        out_valid           <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.req_clear  = (req_data.op == OP_CLEAR);
  assign sts.sweep_last = &sweep_cnt;
  assign sts.out_stall  = out_valid && !rsp_ready;

  assign rsp_valid = out_valid;
  assign rsp_data  = rsp_q;

endmodule

// File: hw/rtl/transposition_table_store_probe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transposition_table_store_probe
// Direct-mapped search-result table with depth and age replacement.
// ----------------------------------------------------------------------------
// req carries one operation per item: store, probe with bounds, probe for the
// move only, or clear. rsp returns exactly one result item per request item.
// cfg writes current_age (index 0) and mate_threshold (index 1); it is always
// ready and other indexes are ignored.
// Store and probe: the slot is read from the single port slot memory at the
// accept edge and the read-modify-write completes in the evaluation state,
// when the result is loaded into the output register; the next item is
// accepted only after that load. A clear walks the slot memory one entry
// per cycle; its result follows the walk. After reset the same walk zeroes
// all 65536 slots; req stays not ready during the walk while cfg writes are
// taken as ever.
// A result held by a stalled receiver does not block the next accept; only
// the following write-back waits until the output register is free.
// ----------------------------------------------------------------------------
module transposition_table_store_probe import ttsp_pkg::*; (
  input logic     clk,
  input logic     rst,
  ttsp_req_if.sink   req,
  ttsp_rsp_if.source rsp,
  ttsp_cfg_if.sink   cfg
);

  ttsp_cmd_t cmd;
  ttsp_sts_t sts;

  assign cfg.ready = 1'b1;

  ttsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttsp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req.data),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

endmodule

// File: verif/ttsp_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsp_table_checker
// Watches the request, response and config channels of the transposition
// table, keeps its own copy of the slots, counters and registers, works out
// the answer to every accepted request and compares each accepted response,
// field by field, against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module ttsp_table_checker import ttsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  ttsp_req_if  req,
  ttsp_rsp_if  rsp,
  ttsp_cfg_if  cfg,
  output int   errors,
  output int   pending
);

  ttsp_slot_t  slots [int];
  logic [31:0] hit_cnt;
  logic [31:0] fresh_cnt;
  logic [7:0]  age_reg;
  logic [14:0] thr_reg;
  ttsp_rsp_t   answer_q [$];
  ttsp_rsp_t   want;
  ttsp_rsp_t   got;

  function automatic int clamp_score(int v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] seen,
                               input logic [63:0] wanted);
    $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, seen,
             wanted);
    errors++;
  endtask

  task automatic run_table_op(input ttsp_req_t r, output ttsp_rsp_t a);
    int         idx;
    int         s;
    int         thr;
    int         al;
    int         be;
    bit         take;
    ttsp_slot_t cur;
    idx = int'(r.pos_key[IDX_W-1:0]);
    cur = slots.exists(idx) ? slots[idx] : '0;
    thr = int'(thr_reg);
    a = '0;
    case (r.op)
      OP_STORE: begin
        take = 1'b0;
        if (cur.key == 64'd0) begin
          fresh_cnt++;
          take = 1'b1;
        end else if (cur.age < age_reg || cur.depth <= r.search_depth) begin
          take = 1'b1;
        end
        if (take) begin
          s = clamp_score(int'($signed(r.score_in)));
          if (s > thr) s = clamp_score(s + int'(r.ply));
          else if (s < -thr) s = clamp_score(s - int'(r.ply));
          cur.key   = r.pos_key;
          cur.move  = r.move_in;
          cur.score = 16'(s);
          cur.depth = r.search_depth;
          cur.bound = r.bound_kind;
          cur.age   = age_reg;
          slots[idx] = cur;
          a.was_stored = 1'b1;
        end
      end
      OP_PROBE, OP_PROBE_MOVE: begin
        if (cur.key == r.pos_key) begin
          a.key_matched = 1'b1;
          a.move_out = cur.move;
          if (r.op == OP_PROBE && cur.depth >= r.search_depth) begin
            hit_cnt++;
            s = int'($signed(cur.score));
            if (s > thr) s = clamp_score(s - int'(r.ply));
            else if (s < -thr) s = clamp_score(s + int'(r.ply));
            al = clamp_score(int'($signed(r.alpha)));
            be = clamp_score(int'($signed(r.beta)));
            case (cur.bound)
              BOUND_UPPER: begin
                if (s <= al) begin
                  a.cutoff = 1'b1;
                  a.score_out = 16'(al);
                end
              end
              BOUND_LOWER: begin
                if (s >= be) begin
                  a.cutoff = 1'b1;
                  a.score_out = 16'(be);
                end
              end
              BOUND_EXACT: begin
                a.cutoff = 1'b1;
                a.score_out = 16'(s);
              end
              default: ;
            endcase
          end
        end
      end
      default: begin
        slots.delete();
        fresh_cnt = '0;
      end
    endcase
    a.probe_hits = hit_cnt;
    a.new_writes = fresh_cnt;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      slots.delete();
      answer_q.delete();
      hit_cnt = '0;
      fresh_cnt = '0;
      age_reg = '0;
      thr_reg = MATE_THR_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_CURRENT_AGE) age_reg = cfg.data[7:0];
        else if (cfg.index == CFG_MATE_THRESHOLD) thr_reg = cfg.data[14:0];
      end
      if (req.valid && req.ready) begin
        run_table_op(req.data, want);
        answer_q.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        if (answer_q.size() == 0) begin
          note_mismatch("result with no request outstanding", 64'(got), '0);
        end else begin
          want = answer_q.pop_front();
          if (got.key_matched !== want.key_matched)
            note_mismatch("key_matched", 64'(got.key_matched), 64'(want.key_matched));
          if (got.cutoff !== want.cutoff)
            note_mismatch("cutoff", 64'(got.cutoff), 64'(want.cutoff));
          if (got.move_out !== want.move_out)
            note_mismatch("move_out", 64'(got.move_out), 64'(want.move_out));
          if (got.score_out !== want.score_out)
            note_mismatch("score_out", 64'(got.score_out), 64'(want.score_out));
          if (got.was_stored !== want.was_stored)
            note_mismatch("was_stored", 64'(got.was_stored), 64'(want.was_stored));
          if (got.probe_hits !== want.probe_hits)
            note_mismatch("probe_hits", 64'(got.probe_hits), 64'(want.probe_hits));
          if (got.new_writes !== want.new_writes)
            note_mismatch("new_writes", 64'(got.new_writes), 64'(want.new_writes));
        end
      end
    end
    pending <= answer_q.size();
  end

endmodule

// File: verif/transposition_table_store_probe_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transposition_table_store_probe_tb
// Drives stores, probes and clears into the transposition table: a directed
// run over the corner cases, then random phases with varied age and mate
// threshold settings and varied sender gaps and receiver stalls, including a
// long receiver hold-off. Checking is done by the table checker alongside.
// ----------------------------------------------------------------------------
module transposition_table_store_probe_tb;
  import ttsp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 155;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOT_SLOTS    = 24;
  localparam int KEY_HISTORY  = 40;

  localparam logic [1:0] BOUND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = CFG_IDX_W'(15);

  localparam logic [63:0] K1  = 64'h0123_4567_89AB_0005;
  localparam logic [63:0] K1B = 64'hFEDC_BA98_7654_0005;
  localparam logic [63:0] K2  = 64'h8000_0000_0000_0007;
  localparam logic [63:0] K3  = 64'h0000_0001_0000_0009;
  localparam logic [63:0] K4  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] K5  = 64'h5555_AAAA_5555_0011;
  localparam logic [63:0] K6  = 64'h0000_0000_0000_8000;
  localparam logic [63:0] K7  = 64'h1111_0000_0000_8001;

  logic clk;
  logic rst;

  ttsp_req_if req_ch ();
  ttsp_rsp_if rsp_ch ();
  ttsp_cfg_if cfg_ch ();

  int err_count;
  int open_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  bit hold_req;
  int thr_now;
  int clear_at;
  int ph;
  int n;

  logic [15:0] hot_idx [HOT_SLOTS];
  logic [47:0] hot_hi [4];
  logic [63:0] seen_keys [$];
  ttsp_req_t   clear_item;

  int phase_age [PHASES] = '{1, 2, 255, 0, 128, 255};
  int phase_thr [PHASES] = '{29000, 0, 32767, 100, 16384, 29000};

  transposition_table_store_probe dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  ttsp_table_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .cfg     (cfg_ch),
    .errors  (err_count),
    .pending (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("transposition_table_store_probe test failed");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic ttsp_req_t mk(op_t op, logic [63:0] key, logic [24:0] mv,
                                   logic signed [15:0] sc, logic [1:0] bd,
                                   logic [5:0] dp, logic [5:0] pl,
                                   logic signed [15:0] al, logic signed [15:0] be);
    ttsp_req_t it;
    it.op = op;
    it.pos_key = key;
    it.move_in = mv;
    it.score_in = sc;
    it.bound_kind = bd;
    it.search_depth = dp;
    it.ply = pl;
    it.alpha = al;
    it.beta = be;
    return it;
  endfunction

  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 64'd0;
    if (r < 10) return {$urandom, $urandom};
    return {hot_hi[$urandom_range(3)], hot_idx[$urandom_range(HOT_SLOTS-1)]};
  endfunction

  function automatic logic signed [15:0] pick_score();
    int v;
    case ($urandom_range(9))
      0: v = -32768;
      1: v = 32767;
      2: v = -32767;
      3, 4: begin
        v = thr_now - 70 + int'($urandom_range(140));
        if (v > 32767) v = 32767;
        if ($urandom_range(1)) v = -v;
      end
      5: v = int'(16'($urandom));
      default: v = int'($urandom_range(2000)) - 1000;
    endcase
    return 16'(v);
  endfunction

  function automatic ttsp_req_t rand_item();
    ttsp_req_t it;
    int r;
    r = $urandom_range(99);
    it.op = (r < 45) ? OP_STORE : (r < 85) ? OP_PROBE : OP_PROBE_MOVE;
    if (it.op != OP_STORE && seen_keys.size() > 0 && $urandom_range(1))
      it.pos_key = seen_keys[$urandom_range(seen_keys.size() - 1)];
    else
      it.pos_key = pick_key();
    it.move_in = 25'($urandom);
    it.score_in = pick_score();
    it.bound_kind = ($urandom_range(9) == 0) ? BOUND_UNUSED : 2'($urandom_range(2));
    if (it.op == OP_STORE)
      it.search_depth = $urandom_range(2) ? 6'($urandom_range(20)) : 6'($urandom);
    else
      it.search_depth = $urandom_range(3) ? 6'($urandom_range(15)) : 6'($urandom);
    it.ply = 6'($urandom);
    it.alpha = pick_score();
    it.beta = pick_score();
    return it;
  endfunction

  task automatic send_item(input ttsp_req_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    if (it.op == OP_STORE) begin
      seen_keys.push_back(it.pos_key);
      if (seen_keys.size() > KEY_HISTORY) void'(seen_keys.pop_front());
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [7:0] age, input logic [14:0] thr,
                          input bit junk);
    write_reg(CFG_CURRENT_AGE, {8'($urandom), age});
    write_reg(CFG_MATE_THRESHOLD, {1'($urandom), thr});
    if (junk) begin
      write_reg(CFG_UNUSED_LO, 16'($urandom));
      write_reg(CFG_UNUSED_HI, 16'hFFFF);
    end
    cfg_ch.valid <= 1'b0;
    thr_now = int'(thr);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    wait (open_count == 0);
    @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    cycle_count = 0;
    thr_now = int'(MATE_THR_RESET);
    hot_idx[0] = 16'h0000;
    hot_idx[1] = 16'hFFFF;
    hot_idx[2] = 16'h0001;
    hot_idx[3] = 16'h8000;
    for (int i = 4; i < HOT_SLOTS; i++) hot_idx[i] = 16'($urandom);
    hot_hi[0] = '0;
    hot_hi[1] = '1;
    hot_hi[2] = 48'({$urandom, $urandom});
    hot_hi[3] = 48'({$urandom, $urandom});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_regs(8'd0, MATE_THR_RESET, 1'b1);

    // directed corner cases
    send_item(mk(OP_PROBE, 64'd0, 25'd0, 16'sd0, BOUND_UPPER, 6'd0, 6'd0, 16'sd0, 16'sd0));
    send_item(mk(OP_STORE, 64'd0, 25'h1FFFFFF, 16'sd100, BOUND_EXACT, 6'd63, 6'd0,
                 16'sd0, 16'sd0));
    send_item(mk(OP_STORE, K1, 25'h1FFFFFF, 16'sd32767, BOUND_EXACT, 6'd63, 6'd63,
                 16'sd0, 16'sd0));
    send_item(mk(OP_PROBE, K1, 25'd0, 16'sd0, BOUND_UPPER, 6'd63, 6'd63, 16'sh8000,
                 16'sd32767));
    send_item(mk(OP_STORE, K1, 25'h0AAAAAA, 16'sd0, BOUND_UPPER, 6'd10, 6'd0,
                 16'sd0, 16'sd0));
    send_item(mk(OP_STORE, K1B, 25'h1555555, -16'sd100, BOUND_LOWER, 6'd63, 6'd1,
                 16'sd0, 16'sd0));
    send_item(mk(OP_PROBE_MOVE, K1, 25'd0, 16'sd0, BOUND_UPPER, 6'd0, 6'd0,
                 16'sd0, 16'sd0));
    send_item(mk(OP_STORE, K2, 25'h1234567, 16'sh8000, BOUND_LOWER, 6'd20, 6'd5,
                 16'sd0, 16'sd0));
    send_item(mk(OP_PROBE, K2, 25'd0, 16'sd0, BOUND_UPPER, 6'd21, 6'd5, 16'sd0, 16'sd0));
    send_item(mk(OP_PROBE, K2, 25'd0, 16'sd0, BOUND_UPPER, 6'd20, 6'd5, 16'sd0,
                 16'sh8000));
    send_item(mk(OP_STORE, K3, 25'h0000001, 16'sd100, BOUND_UPPER, 6'd5, 6'd0,
                 16'sd0, 16'sd0));
    send_item(mk(OP_PROBE, K3, 25'd0, 16'sd0, BOUND_UPPER, 6'd5, 6'd0, 16'sd200, 16'sd0));
    send_item(mk(OP_PROBE, K3, 25'd0, 16'sd0, BOUND_UPPER, 6'd0, 6'd0, 16'sd50, 16'sd0));
    send_item(mk(OP_STORE, K4, 25'h1000000, 16'sd0, BOUND_UNUSED, 6'd1, 6'd0,
                 16'sd0, 16'sd0));
    send_item(mk(OP_PROBE, K4, 25'd0, 16'sd0, BOUND_UPPER, 6'd0, 6'd0, 16'sd0, 16'sd0));
    send_item(mk(OP_STORE, K5, 25'h0ABCDEF, 16'sd500, BOUND_LOWER, 6'd8, 6'd0,
                 16'sd0, 16'sd0));
    send_item(mk(OP_PROBE, K5, 25'd0, 16'sd0, BOUND_UPPER, 6'd8, 6'd0, 16'sd0, 16'sd400));
    send_item(mk(OP_PROBE, K5, 25'd0, 16'sd0, BOUND_UPPER, 6'd8, 6'd0, 16'sd0, 16'sd600));
    send_item(mk(OP_STORE, K6, 25'h0000100, 16'sd29000, BOUND_EXACT, 6'd7, 6'd9,
                 16'sd0, 16'sd0));
    send_item(mk(OP_STORE, K7, 25'h0000200, -16'sd29001, BOUND_EXACT, 6'd7, 6'd10,
                 16'sd0, 16'sd0));
    send_item(mk(OP_PROBE, K7, 25'd0, 16'sd0, BOUND_UPPER, 6'd7, 6'd3, 16'sd0, 16'sd0));
    send_item(mk(OP_PROBE, K6, 25'd0, 16'sd0, BOUND_UPPER, 6'd7, 6'd9, 16'sd0, 16'sd0));
    send_item(mk(OP_CLEAR, 64'd0, 25'd0, 16'sd0, BOUND_UPPER, 6'd0, 6'd0, 16'sd0, 16'sd0));
    send_item(mk(OP_PROBE, K3, 25'd0, 16'sd0, BOUND_UPPER, 6'd0, 6'd0, 16'sd0, 16'sd0));
    send_item(mk(OP_PROBE, 64'd0, 25'd0, 16'sd0, BOUND_UPPER, 6'd0, 6'd0, 16'sd0,
                 16'sd0));

    // random phases
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      set_regs(8'(phase_age[ph]), 15'(phase_thr[ph]), ph == 3);
      send_idle_pct = (ph % 4 == 1) ? 69 : (ph % 4 == 3) ? 7 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 69 : (ph % 4 == 3) ? 7 : 0;
      if (ph == 2) hold_req = 1'b1;
      clear_at = (ph == 2 || ph == 4) ? int'($urandom_range(20, PHASE_ITEMS - 20)) : -1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == clear_at) begin
          clear_item = rand_item();
          clear_item.op = OP_CLEAR;
          send_item(clear_item);
        end else begin
          send_item(rand_item());
        end
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("transposition_table_store_probe test passed");
    end else begin
      $display("transposition_table_store_probe test failed");
    end
    $finish;
  end

endmodule

// File: transposition_table_store_probe.f
hw/rtl/ttsp_pkg.sv
hw/rtl/ttsp_if.sv
hw/rtl/ttsp_ctrl.sv
hw/rtl/ttsp_dp.sv
hw/rtl/transposition_table_store_probe.sv
verif/ttsp_table_checker.sv
verif/transposition_table_store_probe_tb.sv
